// File: hw/rtl/sli_pkg.sv
// Shared types and constants for the sorted list block.
package sli_pkg;

  // Default list capacity
  localparam int unsigned DEPTH_DEF = 16;
  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;

  // Mode codes on the input word
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_PRINT  = 2'd2;

  // Status codes on the result word
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_PRINT,
    OP_NONE
  } op_e;

  // Classified word handed from front to back
  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
  } item_t;

endpackage

// File: hw/rtl/sli_front.sv
// Front end: accepts input words, classifies the mode and queues them.
module sli_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [sli_pkg::VALUE_W-1:0]  value_i,
  output logic                                item_valid_o,
  output sli_pkg::item_t                      item_o,
  input  logic                                item_pop_i
);

  localparam int unsigned QD = sli_pkg::QUEUE_DEPTH;
  localparam int unsigned QW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned FW = $clog2(QD + 1);

  sli_pkg::item_t      queue_q [QD];
  logic [QW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]       fill_q, fill_d;
  sli_pkg::item_t      item_in;
  logic                push;
  logic                pop;

  // Classify the incoming mode
  always_comb begin
    item_in.value = value_i;
    unique case (mode_i)
      sli_pkg::MODE_INSERT: item_in.op = sli_pkg::OP_INSERT;
      sli_pkg::MODE_DELETE: item_in.op = sli_pkg::OP_DELETE;
      sli_pkg::MODE_PRINT:  item_in.op = sli_pkg::OP_PRINT;
      default:              item_in.op = sli_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o   = (fill_q == FW'(QD));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (fill_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the queued word
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// File: hw/rtl/sli_back.sv
// Back end: compare-and-shift list of cells, print sequencer and result register.
module sli_back #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  input  sli_pkg::item_t                      item_i,
  output logic                                item_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [sli_pkg::POS_W-1:0]           position_o,
  output logic signed [sli_pkg::VALUE_W-1:0]  element_o,
  output logic                                last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = sli_pkg::VALUE_W;

  typedef enum logic {
    ST_IDLE,
    ST_PRINT
  } state_e;

  state_e                      state_q;
  logic [CW-1:0]               count_q;
  logic [CW-1:0]               pidx_q;
  logic                        out_valid_q;
  logic [1:0]                  status_q;
  logic [sli_pkg::POS_W-1:0]   position_q;
  logic signed [VW-1:0]        element_q;
  logic                        last_q;

  logic signed [VW-1:0]        entries_q  [DEPTH];
  logic signed [VW-1:0]        entries_d  [DEPTH];
  logic signed [VW-1:0]        up         [DEPTH];
  logic signed [VW-1:0]        down       [DEPTH];
  logic [DEPTH-1:0]            live;
  logic [DEPTH-1:0]            ge;
  logic [DEPTH-1:0]            eq;
  logic [DEPTH-1:0]            mark;
  logic                        full;
  logic                        found;
  logic                        out_free;
  logic                        take;
  logic                        do_ins;
  logic                        do_del;
  logic                        do_rot;
  logic [CW-1:0]               last_idx;
  logic [31:0]                 pos_next;

  // Compare the key against every cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i] = (CW'(i) < count_q);
      ge[i]   = live[i] && (entries_q[i] >= item_i.value);
      eq[i]   = live[i] && (entries_q[i] == item_i.value);
      mark[i] = ge[i] || !live[i];
    end
  end

  // Neighbour taps for shifting
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      up[i]       = entries_q[i + 1];
      down[i + 1] = entries_q[i];
    end
    up[DEPTH-1] = entries_q[DEPTH-1];
    down[0]     = entries_q[0];
  end

  assign full     = (count_q == CW'(DEPTH));
  assign found    = |eq;
  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = (state_q == ST_IDLE) && item_valid_i && out_free;
  assign do_ins   = take && (item_i.op == sli_pkg::OP_INSERT) && !full;
  assign do_del   = take && (item_i.op == sli_pkg::OP_DELETE) && found;
  assign do_rot   = (take && (item_i.op == sli_pkg::OP_PRINT) && (count_q != '0))
                 || ((state_q == ST_PRINT) && out_free);
  assign last_idx = count_q - 1'b1;
  assign pos_next = 32'(pidx_q) + 32'd1;

  assign item_pop_o = take;

  // Shift in on insert, close the gap on delete, rotate on print
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      if (do_ins && mark[i]) begin
        if (i == 0) begin
          entries_d[i] = item_i.value;
        end else if (mark[i-1]) begin
          entries_d[i] = down[i];
        end else begin
          entries_d[i] = item_i.value;
        end
      end else if (do_del && ge[i]) begin
        entries_d[i] = up[i];
      end else if (do_rot) begin
        if (CW'(i) < last_idx) begin
          entries_d[i] = up[i];
        end else if (CW'(i) == last_idx) begin
          entries_d[i] = entries_q[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_q[i] <= entries_d[i];
    end
  end

  // Hold state, count and the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pidx_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= sli_pkg::ST_OK;
      position_q  <= '0;
      element_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            out_valid_q <= 1'b1;
            status_q    <= sli_pkg::ST_OK;
            position_q  <= '0;
            element_q   <= '0;
            last_q      <= 1'b1;
            unique case (item_i.op)
              sli_pkg::OP_INSERT: begin
                if (full) begin
                  status_q <= sli_pkg::ST_FULL;
                end else begin
                  count_q <= count_q + 1'b1;
                end
              end
              sli_pkg::OP_DELETE: begin
                if (count_q == '0) begin
                  status_q <= sli_pkg::ST_EMPTY;
                end else if (!found) begin
                  status_q <= sli_pkg::ST_MISSING;
                end else begin
                  count_q <= count_q - 1'b1;
                end
              end
              sli_pkg::OP_PRINT: begin
                if (count_q == '0) begin
                  status_q <= sli_pkg::ST_EMPTY;
                end else begin
                  position_q <= sli_pkg::POS_W'(1);
                  element_q  <= entries_q[0];
                  last_q     <= (count_q == CW'(1));
                  pidx_q     <= CW'(1);
                  if (count_q != CW'(1)) begin
                    state_q <= ST_PRINT;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_PRINT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= sli_pkg::ST_OK;
            position_q  <= pos_next[sli_pkg::POS_W-1:0];
            element_q   <= entries_q[0];
            last_q      <= (pidx_q == last_idx);
            pidx_q      <= pidx_q + 1'b1;
            if (pidx_q == last_idx) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = position_q;
  assign element_o   = element_q;
  assign last_o      = last_q;

endmodule

// File: hw/rtl/sorted_list_insert_delete.sv
// Sorted list block: bounded list of signed values kept in ascending order.
//
// Input channel (in_valid_i / in_stall_o): one word per operation, mode_i
// selects insert, delete or print, value_i carries the value or key.
// Output channel (out_valid_o / out_stall_i): result words with status,
// position, element and a last flag closing the results of one operation.
// A word moves when valid is high and stall is low at a rising clock edge.
// The input word is first stored in the queue, then taken by the back end,
// which registers its first result word; a stall on either side can delay it.
// Insert, delete and unused modes give one result word each; print gives one
// result word per stored entry (at least one), as the list rotates one cell
// per result word, and the back end takes no new word until print is done.
// A two-word queue sits between the front end and the list, so input words
// are taken while the back end is busy printing or waiting on the receiver.
// While the receiver stalls, the result register holds its word and the
// back end waits; the queue fills and then stalls the sender.
// Reset empties the list and the queue and drops any pending result.
module sorted_list_insert_delete #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [sli_pkg::VALUE_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [sli_pkg::POS_W-1:0]           position_o,
  output logic signed [sli_pkg::VALUE_W-1:0]  element_o,
  output logic                                last_o
);

  logic           item_valid;
  sli_pkg::item_t item;
  logic           item_pop;

  // Accept and classify input words
  sli_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Carry out operations on the list
  sli_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .element_o    (element_o),
    .last_o       (last_o)
  );

endmodule

// File: dv/sorted_list_insert_delete_test.sv
// Testbench for the sorted list block: directed and random operations, checked per result word.
`timescale 1ns / 1ps

module sorted_list_insert_delete_test;

  localparam int unsigned LIST_DEPTH = sli_pkg::DEPTH_DEF;
  // Mode 3 has no operation behind it; it only answers with a plain ok
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [sli_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [sli_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam int unsigned IDLE_PCT = 35;
  localparam int unsigned DRAIN_LIMIT = 50000;

  typedef struct packed {
    logic [1:0]                         status;
    logic [sli_pkg::POS_W-1:0]          position;
    logic signed [sli_pkg::VALUE_W-1:0] element;
    logic                               last;
  } result_word_t;

  logic                               clk_i;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic [1:0]                         mode_i = sli_pkg::MODE_INSERT;
  logic signed [sli_pkg::VALUE_W-1:0] value_i = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic [1:0]                         status_o;
  logic [sli_pkg::POS_W-1:0]          position_o;
  logic signed [sli_pkg::VALUE_W-1:0] element_o;
  logic                               last_o;

  // Shadow copy of the list, ascending, and the result words still owed
  logic signed [sli_pkg::VALUE_W-1:0] shadow_list[$];
  result_word_t                       expected_words[$];
  int unsigned                        fault_count = 0;
  logic                               steady = 1'b0;

  sorted_list_insert_delete #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .position_o (position_o),
    .element_o  (element_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void owe_word(logic [1:0] status, logic [sli_pkg::POS_W-1:0] position,
                                   logic signed [sli_pkg::VALUE_W-1:0] element, logic last);
    result_word_t w;
    w.status   = status;
    w.position = position;
    w.element  = element;
    w.last     = last;
    expected_words.push_back(w);
  endfunction

  // Apply one accepted operation to the shadow list and queue its result words
  function automatic void apply_list_op(logic [1:0] mode,
                                        logic signed [sli_pkg::VALUE_W-1:0] value);
    int idx;
    idx = -1;
    case (mode)
      sli_pkg::MODE_INSERT: begin
        if (shadow_list.size() >= LIST_DEPTH) begin
          owe_word(sli_pkg::ST_FULL, '0, '0, 1'b1);
        end else begin
          idx = shadow_list.size();
          for (int i = shadow_list.size() - 1; i >= 0; i--) begin
            if (shadow_list[i] >= value) idx = i;
          end
          shadow_list.insert(idx, value);
          owe_word(sli_pkg::ST_OK, '0, '0, 1'b1);
        end
      end
      sli_pkg::MODE_DELETE: begin
        if (shadow_list.size() == 0) begin
          owe_word(sli_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = shadow_list.size() - 1; i >= 0; i--) begin
            if (shadow_list[i] == value) idx = i;
          end
          if (idx < 0) begin
            owe_word(sli_pkg::ST_MISSING, '0, '0, 1'b1);
          end else begin
            shadow_list.delete(idx);
            owe_word(sli_pkg::ST_OK, '0, '0, 1'b1);
          end
        end
      end
      sli_pkg::MODE_PRINT: begin
        if (shadow_list.size() == 0) begin
          owe_word(sli_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_list.size(); i++) begin
            owe_word(sli_pkg::ST_OK, sli_pkg::POS_W'(i + 1), shadow_list[i],
                     i == shadow_list.size() - 1);
          end
        end
      end
      default: begin
        owe_word(sli_pkg::ST_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // Mix of small values for duplicates, full-range values and the extremes
  function automatic logic signed [sli_pkg::VALUE_W-1:0] pick_value();
    logic signed [sli_pkg::VALUE_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1, 2: v = $signed($urandom_range(16)) - 8;
      default: begin
        case ($urandom_range(3))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = '0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Mostly a stored value, so that deletes hit
  function automatic logic signed [sli_pkg::VALUE_W-1:0] pick_key();
    if (shadow_list.size() != 0 && $urandom_range(99) < 70)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    return pick_value();
  endfunction

  // Offer one word, hold it until taken, then predict its results
  task automatic send_word(input logic [1:0] mode,
                           input logic signed [sli_pkg::VALUE_W-1:0] value);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_list_op(mode, value);
  endtask

  // Hold the sender until every owed word has come back
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_words.size() != 0) begin
      $display("%0t: %0d result words never arrived", $realtime, expected_words.size());
      fault_count++;
      expected_words.delete();
    end
  endtask

  // Receiver: random stall, and check each word taken against the oldest owed
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(out_valid_o)) begin
        $display("%0t: out_valid_o unknown", $realtime);
        fault_count++;
      end else if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word status %0d position %0d element %0d last %0d",
                   $realtime, status_o, position_o, element_o, last_o);
          fault_count++;
        end else begin
          result_word_t w;
          w = expected_words.pop_front();
          if (status_o !== w.status || position_o !== w.position ||
              element_o !== w.element || last_o !== w.last) begin
            $display("%0t: mismatch expected status %0d position %0d element %0d last %0d",
                     $realtime, w.status, w.position, w.element, w.last);
            $display("%0t:              got status %0d position %0d element %0d last %0d",
                     $realtime, status_o, position_o, element_o, last_o);
            fault_count++;
          end
        end
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // Print, delete and the unused mode on an empty list
  task automatic test_empty_list();
    send_word(sli_pkg::MODE_PRINT, VAL_MAX);
    send_word(sli_pkg::MODE_DELETE, '0);
    send_word(MODE_UNUSED, VAL_MIN);
  endtask

  // Extremes, duplicates, a missing key, a delete in the middle and one at the low end
  task automatic test_extreme_values();
    send_word(sli_pkg::MODE_INSERT, VAL_MAX);
    send_word(sli_pkg::MODE_INSERT, VAL_MIN);
    send_word(sli_pkg::MODE_INSERT, '0);
    send_word(sli_pkg::MODE_INSERT, '0);
    send_word(sli_pkg::MODE_INSERT, -1);
    send_word(sli_pkg::MODE_PRINT, '0);
    send_word(sli_pkg::MODE_DELETE, 5);
    send_word(sli_pkg::MODE_DELETE, '0);
    send_word(sli_pkg::MODE_DELETE, VAL_MIN);
    send_word(sli_pkg::MODE_PRINT, -1);
  endtask

  // Fill to capacity, overflow once, print the whole list
  task automatic test_full_list();
    while (shadow_list.size() < LIST_DEPTH) send_word(sli_pkg::MODE_INSERT, pick_value());
    send_word(sli_pkg::MODE_INSERT, VAL_MIN);
    send_word(sli_pkg::MODE_PRINT, '0);
  endtask

  // Random operations with a bias towards filling or emptying
  task automatic test_random_traffic(input int unsigned n_words, input int unsigned insert_pct);
    int unsigned pick;
    for (int unsigned k = 0; k < n_words; k++) begin
      pick = $urandom_range(99);
      if (pick < 3)
        send_word(MODE_UNUSED, pick_value());
      else if (pick < 15)
        send_word(sli_pkg::MODE_PRINT, pick_value());
      else if ($urandom_range(99) < insert_pct)
        send_word(sli_pkg::MODE_INSERT, pick_value());
      else
        send_word(sli_pkg::MODE_DELETE, pick_key());
    end
  endtask

  // Back-to-back traffic with neither side idling
  task automatic test_steady_stream(input int unsigned n_words);
    steady <= 1'b1;
    test_random_traffic(n_words, 55);
    steady <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_extreme_values();
    test_full_list();
    test_random_traffic(120, 25);
    test_random_traffic(120, 75);
    test_steady_stream(80);
    drain_results();
    test_random_traffic(130, 50);
    drain_results();
    repeat (40) @(posedge clk_i);

    if (fault_count == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
